FILE: design/checksummed_frame_receiver_fifo_macros.svh
// Assertion macros for the checksummed frame receiver.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef CHECKSUMMED_FRAME_RECEIVER_FIFO_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_FIFO_MACROS_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is asserted
`define CFRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also covers the reset cycles
`define CFRF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFRF_ASSERT(lbl, prop, msg)
`define CFRF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: design/cfrf_pkg.sv
// Shared types, codes and helpers for the checksummed frame receiver.
// No dependencies; imported by every module of the block.
package cfrf_pkg;

  // ring geometry: FIFO_DEPTH slots, FIFO_DEPTH - 1 usable frames
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned SLOT_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // control bytes carry this flag
  localparam logic [7:0] CONTROL_FLAG = 8'h80;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_COMMIT    = 3'd1,
    ST_CKSUM_ERR = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_POPPED    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // receive phase, one-hot
  typedef enum logic [3:0] {
    PH_CTRL  = 4'b0001,
    PH_DATA1 = 4'b0010,
    PH_DATA2 = 4'b0100,
    PH_CKSUM = 4'b1000
  } phase_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] rx_byte;
  } cfrf_req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_control;
    logic [7:0] frame_data_first;
    logic [7:0] frame_data_second;
  } cfrf_rsp_t;

  // ring index increment with wrap
  function automatic slot_t next_slot(slot_t s);
    if (s == slot_t'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return s + slot_t'(1);
  endfunction

endpackage

FILE: design/cfrf_in_stage.sv
// Input register stage of the frame receiver.
// Depends on cfrf_pkg for the request type.
module cfrf_in_stage
  import cfrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cfrf_req_t in_req,
  input  logic      adv,
  output logic      s1_valid,
  output cfrf_req_t s1_req
);

  logic      valid_r, valid_nxt;
  cfrf_req_t req_r;
  logic      accept;

  // hold off the sender only when the staged request cannot move on
  assign in_stall = valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  assign s1_valid = valid_r;
  assign s1_req   = req_r;

endmodule

FILE: design/cfrf_core.sv
// Frame parser, checksum and frame ring of the receiver.
// Depends on cfrf_pkg and the assertion macro header.
`include "checksummed_frame_receiver_fifo_macros.svh"
module cfrf_core
  import cfrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  cfrf_req_t req,
  output cfrf_rsp_t rsp
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  slot_t      wr_slot_r, wr_slot_nxt;
  slot_t      rd_slot_r, rd_slot_nxt;
  logic       wr_en;
  logic [1:0] lane;

  // frame ring: byte 0 control, byte 1 first data, byte 2 second data
  logic [2:0][7:0] store_r [FIFO_DEPTH];

  // decode one request against the current state
  always_comb begin
    rsp.status            = ST_TAKEN;
    rsp.frame_control     = '0;
    rsp.frame_data_first  = '0;
    rsp.frame_data_second = '0;
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    wr_en       = 1'b0;
    lane        = 2'd0;
    if (req.opcode == OP_POP) begin
      if (rd_slot_r == wr_slot_r) begin
        rsp.status = ST_EMPTY;
      end else begin
        rsp.status            = ST_POPPED;
        rsp.frame_control     = store_r[rd_slot_r][0];
        rsp.frame_data_first  = store_r[rd_slot_r][1];
        rsp.frame_data_second = store_r[rd_slot_r][2];
        rd_slot_nxt           = next_slot(rd_slot_r);
      end
    end else begin
      unique case (phase_r)
        PH_CTRL: begin
          // bytes without the control flag are dropped while hunting
          if ((req.rx_byte & CONTROL_FLAG) != 8'h00) begin
            wr_en     = 1'b1;
            lane      = 2'd0;
            sum_nxt   = sum_r + req.rx_byte;
            phase_nxt = PH_DATA1;
          end
        end
        PH_DATA1: begin
          wr_en     = 1'b1;
          lane      = 2'd1;
          sum_nxt   = sum_r + req.rx_byte;
          phase_nxt = PH_DATA2;
        end
        PH_DATA2: begin
          wr_en     = 1'b1;
          lane      = 2'd2;
          sum_nxt   = sum_r + req.rx_byte;
          phase_nxt = PH_CKSUM;
        end
        PH_CKSUM: begin
          if (sum_r == req.rx_byte) begin
            if (next_slot(wr_slot_r) == rd_slot_r) begin
              rsp.status = ST_OVERFLOW;
            end else begin
              rsp.status  = ST_COMMIT;
              wr_slot_nxt = next_slot(wr_slot_r);
            end
          end else begin
            rsp.status = ST_CKSUM_ERR;
          end
          phase_nxt = PH_CTRL;
          sum_nxt   = '0;
        end
        default: begin
          phase_nxt = PH_CTRL;
          sum_nxt   = '0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CTRL;
      sum_r     <= '0;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
    end
  end

  // frame bytes land in the slot being assembled
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      store_r[wr_slot_r][lane] <= req.rx_byte;
    end
  end

  // reset leaves an empty ring hunting for a control byte
  `CFRF_ASSERT_RST(a_reset_clean, (!rst_n) |=> (rd_slot_r == wr_slot_r && phase_r == PH_CTRL), "ring not empty after reset")
  // a commit moves the write slot
  `CFRF_ASSERT(a_commit_moves, (fire && rsp.status == ST_COMMIT) |=> (wr_slot_r != $past(wr_slot_r)), "commit did not advance write slot")
  // a pop moves the read slot
  `CFRF_ASSERT(a_pop_moves, (fire && rsp.status == ST_POPPED) |=> (rd_slot_r != $past(rd_slot_r)), "pop did not advance read slot")
  // a frame dropped for a bad checksum or a full ring restarts the parser
  `CFRF_ASSERT(a_frame_end, (fire && (rsp.status == ST_CKSUM_ERR || rsp.status == ST_OVERFLOW)) |=> (phase_r == PH_CTRL && sum_r == 8'h00), "parser not restarted")

endmodule

FILE: design/checksummed_frame_receiver_fifo.sv
// Top level of the checksummed frame receiver with its frame ring.
// Depends on cfrf_pkg, cfrf_in_stage and cfrf_core.
//
// Usage:
//   in_valid/in_stall/in_req carry requests: opcode OP_BYTE delivers one
//   received serial byte, OP_POP asks for the oldest stored frame.
//   out_valid/out_stall/out_rsp return exactly one response per request, in
//   order: a status code and, for a pop, the three frame bytes.
//   A frame is a control byte with bit 7 set, two data bytes and a byte that
//   equals the sum of all three modulo 256; good frames go into a
//   FIFO_DEPTH-slot ring that holds FIFO_DEPTH - 1 frames, bad frames and
//   frames that find the ring full are dropped with an error status.
//   A request passes through the input register and then the response
//   register; the parser and ring update combinationally between the two.
//   Throughput: one request per cycle while out_stall is low.
//   Reset (rst_n low, synchronous) empties the ring and returns the parser
//   to hunting for a control byte; no clearing pass is needed.
//   While out_stall holds a response, one more request waits in the input
//   register and then in_stall rises; nothing is lost or reordered.
module checksummed_frame_receiver_fifo
  import cfrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cfrf_req_t in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output cfrf_rsp_t out_rsp
);

  logic      s1_valid;
  cfrf_req_t s1_req;
  logic      adv;
  logic      fire;
  cfrf_rsp_t core_rsp;
  logic      out_valid_r, out_valid_nxt;
  cfrf_rsp_t out_rsp_r;

  // the pipeline moves when the response register is free or being taken
  assign adv  = !out_valid_r || !out_stall;
  assign fire = s1_valid && adv;

  cfrf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  cfrf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (s1_req),
    .rsp   (core_rsp)
  );

  // response register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= core_rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
